@@ hdl/upd_pkg.sv @@
package upd_pkg;

  // character codes
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // most results one input word can cause
  localparam int unsigned MAX_RES = 3;

  // register file
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned LIMIT_W     = 16;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;
  localparam logic REG_OUTPUT_LIMIT = 1'b0;

  typedef logic [1:0] res_cnt_t;

  // one result word
  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       last;
    logic       truncated;
  } upd_entry_t;

  // all results of one input word
  typedef struct packed {
    res_cnt_t                 count;
    upd_entry_t [MAX_RES-1:0] entry;
  } upd_bundle_t;

  // escape tracking
  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_PCT   = 3'b010,
    PH_DIGIT = 3'b100
  } upd_phase_e;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c <= 8'h46) begin
      v = c - 8'h37;
    end else begin
      v = c - 8'h57;
    end
    return v[3:0];
  endfunction

endpackage

@@ hdl/upd_decode.sv @@
module upd_decode
  import upd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  input  logic [LIMIT_W-1:0]  limit_i,
  output upd_bundle_t         bundle_o
);

  upd_phase_e         phase_q, phase_d;
  logic [7:0]         held_q, held_d;
  logic [LIMIT_W-1:0] count_q, count_d;
  logic               drop_q, drop_d;

  logic [7:0]         cand [MAX_RES];
  res_cnt_t           k;
  res_cnt_t           n_emit;
  logic               fresh;
  logic [MAX_RES-1:0] below;
  logic [LIMIT_W:0]   cnt_ext;
  logic [LIMIT_W:0]   lim_ext;

  // candidate bytes and next escape state
  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      cand[i] = 8'h00;
    end
    k       = 2'd0;
    fresh   = 1'b1;
    phase_d = PH_IDLE;
    held_d  = held_q;
    case (phase_q)
      PH_PCT: begin
        if (is_hex(byte_i) && !last_i) begin
          held_d  = byte_i;
          phase_d = PH_DIGIT;
          fresh   = 1'b0;
        end else begin
          cand[0] = CH_PERCENT;
          k       = 2'd1;
        end
      end
      PH_DIGIT: begin
        if (is_hex(byte_i) && is_hex(held_q)) begin
          cand[0] = {hex_val(held_q), hex_val(byte_i)};
          k       = 2'd1;
          fresh   = 1'b0;
        end else begin
          cand[0] = CH_PERCENT;
          cand[1] = held_q;
          k       = 2'd2;
        end
        held_d = 8'h00;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
    if (fresh) begin
      if (byte_i == CH_PERCENT && !last_i) begin
        phase_d = PH_PCT;
      end else begin
        cand[k] = (byte_i == CH_PLUS) ? CH_SPACE : byte_i;
        k       = k + 2'd1;
      end
    end
  end

  // limit check on up to three consecutive bytes
  assign cnt_ext = {1'b0, count_q};
  assign lim_ext = {1'b0, limit_i};
  always_comb begin
    for (int j = 0; j < MAX_RES; j++) begin
      below[j] = (cnt_ext + (LIMIT_W + 1)'(j)) < lim_ext;
    end
    n_emit = 2'd0;
    for (int j = 0; j < MAX_RES; j++) begin
      if (res_cnt_t'(j) < k && below[j]) begin
        n_emit = res_cnt_t'(j + 1);
      end
    end
    drop_d  = drop_q | (k > n_emit);
    count_d = count_q + LIMIT_W'(n_emit);
  end

  // result words, end marker handling
  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      bundle_o.entry[i].data       = cand[i];
      bundle_o.entry[i].byte_valid = 1'b1;
      bundle_o.entry[i].last       = 1'b0;
      bundle_o.entry[i].truncated  = 1'b0;
    end
    bundle_o.count = n_emit;
    if (last_i) begin
      if (n_emit == 2'd0) begin
        bundle_o.entry[0].data       = 8'h00;
        bundle_o.entry[0].byte_valid = 1'b0;
        bundle_o.entry[0].last       = 1'b1;
        bundle_o.entry[0].truncated  = drop_d;
        bundle_o.count               = 2'd1;
      end else begin
        bundle_o.entry[n_emit - 2'd1].last      = 1'b1;
        bundle_o.entry[n_emit - 2'd1].truncated = drop_d;
      end
    end
  end

  // per-string state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      held_q  <= 8'h00;
      count_q <= '0;
      drop_q  <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q <= PH_IDLE;
        held_q  <= 8'h00;
        count_q <= '0;
        drop_q  <= 1'b0;
      end else begin
        phase_q <= phase_d;
        held_q  <= held_d;
        count_q <= count_d;
        drop_q  <= drop_d;
      end
    end
  end

endmodule

@@ hdl/url_percent_decoder.sv @@
// an accepted input word is registered, then decoded into the output buffer
// throughput: one input word per cycle while each yields at most one result and
// the output is not stalled; a failed escape yields up to three result words,
// drained one per unstalled cycle; the buffer holds off decoding until free
// reset: asynchronous, active low; clears the escape state, counters and buffers
// and sets the limit to 65535
module url_percent_decoder
  import upd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        in_byte_i,
  input  logic              in_last_i,
  // output channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              byte_valid_o,
  output logic              out_last_o,
  output logic              truncated_o
);

  logic [LIMIT_W-1:0] limit_q;

  logic               in_vld_q;
  logic [7:0]         in_byte_q;
  logic               in_last_q;

  upd_entry_t [MAX_RES-1:0] buf_q;
  res_cnt_t                 rem_q;

  upd_bundle_t bundle;
  logic        in_acc;
  logic        out_acc;
  logic        buf_free;
  logic        step;

  // config register
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_OUTPUT_LIMIT) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_OUTPUT_LIMIT) begin
      prdata = {{(DATA_W-LIMIT_W){1'b0}}, limit_q};
    end
  end

  // handshakes
  assign out_acc    = out_valid_o && !out_stall_i;
  assign buf_free   = (rem_q == 2'd0) || (rem_q == 2'd1 && out_acc);
  assign step       = in_vld_q && buf_free;
  assign in_stall_o = in_vld_q && !step;
  assign in_acc     = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
  end

  upd_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .limit_i  (limit_q),
    .bundle_o (bundle)
  );

  // output buffer, shifts down one word per accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
    end else if (step) begin
      rem_q <= bundle.count;
    end else if (out_acc) begin
      rem_q <= rem_q - 2'd1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (step) begin
      buf_q <= bundle.entry;
    end else if (out_acc) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        buf_q[i] <= buf_q[i+1];
      end
    end
  end

  assign out_valid_o  = rem_q != 2'd0;
  assign out_byte_o   = buf_q[0].data;
  assign byte_valid_o = buf_q[0].byte_valid;
  assign out_last_o   = buf_q[0].last;
  assign truncated_o  = buf_q[0].truncated;

endmodule
